>>> hw/rtl/rrts_pkg.sv
// Shared types and constants for the round-robin task scheduler.
// No dependencies; imported by rrts_cmp, the scheduler core and the testbench.
`default_nettype none

package rrts_pkg;

  localparam int IdW   = 4;
  localparam int DurW  = 32;
  localparam int TickW = 64;
  localparam int WokW  = 5;

  // Task status codes.
  localparam logic [1:0] ST_DEAD    = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_BLOCKED = 2'd3;

  typedef enum logic [2:0] {
    OP_YIELD     = 3'd0,
    OP_BLOCK     = 3'd1,
    OP_UNBLOCK   = 3'd2,
    OP_ADD       = 3'd3,
    OP_TERMINATE = 3'd4,
    OP_SLEEP     = 3'd5,
    OP_TICK      = 3'd6
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DEC,
    S_PUSH,
    S_POP,
    S_POP2,
    S_SI0,
    S_SI1,
    S_SL_A,
    S_SL_B,
    S_SL_C,
    S_SL_FIN,
    S_SL_F2,
    S_SL_F3,
    S_TK0,
    S_TK1,
    S_TK2,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/rrts_cmp.sv
// Shared 64-bit unsigned magnitude comparator for wake-time checks.
// Depends on rrts_pkg for the tick width.
`default_nettype none

module rrts_cmp
  import rrts_pkg::*;
(
  input  wire logic [TickW-1:0] a_i,
  input  wire logic [TickW-1:0] b_i,
  output logic                  gt_o
);

  assign gt_o = (a_i > b_i);

endmodule

`default_nettype wire

>>> hw/rtl/rrts_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
// Contents are undefined until written; no package dependency.
`default_nettype none

module rrts_ram #(
  parameter int W     = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/rrts_vram.sv
// RAM with a valid bit per entry; an entry never written reads as its reset value.
// Entry 0 and the other entries each have their own reset value; no package dependency.
`default_nettype none

module rrts_vram #(
  parameter int             W         = 2,
  parameter int             DEPTH     = 16,
  parameter logic [W-1:0]   RST_FIRST = '0,
  parameter logic [W-1:0]   RST_REST  = '0
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [W-1:0]  rdata_q;
  logic          rvld_q;
  logic [AW-1:0] raddr_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
    raddr_q <= raddr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[raddr_i];
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : ((raddr_q == '0) ? RST_FIRST : RST_REST);

endmodule

`default_nettype wire

>>> hw/rtl/round_robin_task_scheduler_core.sv
// Top level of the round-robin task scheduler with a timed sleep queue.
// Depends on rrts_pkg, rrts_cmp, rrts_ram and rrts_vram.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         in_valid_i / in_stall_o    op_i, task_id_i, duration_i
//   result    out        out_valid_o / out_stall_i  running_task_o, switched_o,
//                                                   woken_count_o, error_o
//   config    in         cfg_we_i (no handshake)    cfg_wdata_i (idle task id)
//
// One beat is handled at a time by a small sequencer that drives one read and
// one write per memory in each cycle and a single shared 64-bit comparator.
// Add and unblock finish in the decode state; a yield-type operation also
// requeues and pops the ready queue, a sleep walks the sleep queue past the
// sleepers that wake no later than it, and a tick removes the expired sleepers
// one by one; each step of a list walk waits for registered memory reads.
// The input stalls from the accept until the result is loaded into the output
// register, so a new beat can be taken while that result still waits.
// Reset is asynchronous and active low; it empties both queues, makes task 0
// running and all others dead through per-entry valid bits, with no clearing pass.
`default_nettype none

module round_robin_task_scheduler_core
  import rrts_pkg::*;
#(
  parameter int NUM_TASKS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [IdW-1:0]    cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        op_i,
  input  wire logic [IdW-1:0]    task_id_i,
  input  wire logic [DurW-1:0]   duration_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [IdW-1:0]         running_task_o,
  output logic                   switched_o,
  output logic [WokW-1:0]        woken_count_o,
  output logic                   error_o
);

  localparam int IW = $clog2(NUM_TASKS);
  localparam int CW = $clog2(NUM_TASKS + 1);

  // Sequencer and queue state.
  state_e            st_q, st_d;
  op_e               op_q, op_d;
  logic [IdW-1:0]    tid_q, tid_d;
  logic [DurW-1:0]   dur_q, dur_d;
  logic [IW-1:0]     prev_q, prev_d;
  logic [IW-1:0]     cur_q, cur_d;
  logic              err_q, err_d;
  logic [WokW-1:0]   woken_q, woken_d;
  logic              push_q, push_d;
  logic [IW-1:0]     rh_q, rh_d;
  logic [IW-1:0]     rt_q, rt_d;
  logic              re_q, re_d;
  logic [IW-1:0]     sh_q, sh_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic [TickW-1:0]  wv_q, wv_d;
  logic [IW-1:0]     p_q, p_d;
  logic [IW-1:0]     nx_q, nx_d;
  logic [CW-1:0]     i_q, i_d;
  logic [IW-1:0]     t_q, t_d;
  logic              blk_q, blk_d;
  logic [IdW-1:0]    idle_q;
  logic              ov_q, ov_d;
  logic [IdW-1:0]    o_task_q, o_task_d;
  logic              o_sw_q, o_sw_d;
  logic [WokW-1:0]   o_wk_q, o_wk_d;
  logic              o_err_q, o_err_d;

  // Memory ports.
  logic          stat_we, slp_we, rl_we, sl_we, wk_we;
  logic [IW-1:0] stat_wa, slp_wa, rl_wa, sl_wa, wk_wa;
  logic [IW-1:0] stat_ra, rl_ra, sl_ra, wk_ra;
  logic [1:0]    stat_wd, stat_rd;
  logic          slp_wd, slp_rd;
  logic [IW-1:0] rl_wd, rl_rd, sl_wd, sl_rd;
  logic [TickW-1:0] wk_wd, wk_rd;

  logic [TickW-1:0] cmp_b;
  logic             cmp_gt;
  logic             in_acc;
  logic [IW-1:0]    idl;
  logic [IW-1:0]    tid_idx;
  logic             tid_ok;
  logic [TickW-1:0] wake_new;

  assign in_acc   = in_valid_i && (st_q == S_IDLE);
  assign idl      = (32'(idle_q) < NUM_TASKS) ? IW'(idle_q) : '0;
  assign tid_idx  = IW'(tid_q);
  assign tid_ok   = (32'(tid_q) < NUM_TASKS);
  assign wake_new = tick_q + TickW'(dur_q);
  assign cmp_b    = (st_q == S_TK1) ? tick_q : wv_q;

  rrts_cmp u_cmp (
    .a_i  (wk_rd),
    .b_i  (cmp_b),
    .gt_o (cmp_gt)
  );

  // Task status: task 0 starts running, the rest dead.
  rrts_vram #(
    .W(2), .DEPTH(NUM_TASKS), .RST_FIRST(ST_RUNNING), .RST_REST(ST_DEAD)
  ) u_stat (
    .clk_i, .rst_ni, .we_i(stat_we), .waddr_i(stat_wa), .wdata_i(stat_wd),
    .raddr_i(stat_ra), .rdata_o(stat_rd)
  );

  // Sleep-queue membership flag, read at the same address as the status.
  rrts_vram #(
    .W(1), .DEPTH(NUM_TASKS), .RST_FIRST(1'b0), .RST_REST(1'b0)
  ) u_slp (
    .clk_i, .rst_ni, .we_i(slp_we), .waddr_i(slp_wa), .wdata_i(slp_wd),
    .raddr_i(stat_ra), .rdata_o(slp_rd)
  );

  rrts_ram #(.W(IW), .DEPTH(NUM_TASKS)) u_rlink (
    .clk_i, .we_i(rl_we), .waddr_i(rl_wa), .wdata_i(rl_wd), .raddr_i(rl_ra),
    .rdata_o(rl_rd)
  );

  rrts_ram #(.W(IW), .DEPTH(NUM_TASKS)) u_slink (
    .clk_i, .we_i(sl_we), .waddr_i(sl_wa), .wdata_i(sl_wd), .raddr_i(sl_ra),
    .rdata_o(sl_rd)
  );

  rrts_ram #(.W(TickW), .DEPTH(NUM_TASKS)) u_wake (
    .clk_i, .we_i(wk_we), .waddr_i(wk_wa), .wdata_i(wk_wd), .raddr_i(wk_ra),
    .rdata_o(wk_rd)
  );

  always_comb begin
    st_d = st_q;  op_d = op_q;  tid_d = tid_q;  dur_d = dur_q;
    prev_d = prev_q;  cur_d = cur_q;  err_d = err_q;  woken_d = woken_q;
    push_d = push_q;  rh_d = rh_q;  rt_d = rt_q;  re_d = re_q;
    sh_d = sh_q;  cnt_d = cnt_q;  tick_d = tick_q;  wv_d = wv_q;
    p_d = p_q;  nx_d = nx_q;  i_d = i_q;  t_d = t_q;  blk_d = blk_q;
    ov_d = ov_q;  o_task_d = o_task_q;  o_sw_d = o_sw_q;
    o_wk_d = o_wk_q;  o_err_d = o_err_q;

    stat_we = 1'b0;  stat_wa = cur_q;  stat_wd = ST_DEAD;  stat_ra = cur_q;
    slp_we  = 1'b0;  slp_wa  = cur_q;  slp_wd  = 1'b0;
    rl_we   = 1'b0;  rl_wa   = rt_q;   rl_wd   = cur_q;    rl_ra = rh_q;
    sl_we   = 1'b0;  sl_wa   = cur_q;  sl_wd   = sh_q;     sl_ra = p_q;
    wk_we   = 1'b0;  wk_wa   = cur_q;  wk_wd   = wake_new; wk_ra = sh_q;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    case (st_q)
      S_IDLE: begin
        // Look up status and sleep flag of the task the beat refers to.
        if (op_i == OP_UNBLOCK || op_i == OP_ADD) begin
          stat_ra = IW'(task_id_i);
        end
        if (in_acc) begin
          op_d    = op_e'(op_i);
          tid_d   = task_id_i;
          dur_d   = duration_i;
          prev_d  = cur_q;
          err_d   = 1'b0;
          woken_d = '0;
          push_d  = 1'b0;
          st_d    = S_DEC;
        end
      end
      S_DEC: begin
        case (op_q)
          OP_YIELD: begin
            push_d = (stat_rd == ST_RUNNING) && (cur_q != idl);
            st_d   = S_PUSH;
          end
          OP_BLOCK, OP_TERMINATE: begin
            if (cur_q == idl) begin
              err_d = 1'b1;
              st_d  = S_OUT;
            end else begin
              stat_we = 1'b1;
              stat_wa = cur_q;
              stat_wd = (op_q == OP_BLOCK) ? ST_BLOCKED : ST_DEAD;
              st_d    = S_PUSH;
            end
          end
          OP_UNBLOCK: begin
            if (!tid_ok || stat_rd != ST_BLOCKED || slp_rd) begin
              err_d = 1'b1;
            end else begin
              // Insert at the front of the ready queue.
              if (re_q) begin
                rt_d = tid_idx;
                re_d = 1'b0;
              end else begin
                rl_we = 1'b1;
                rl_wa = tid_idx;
                rl_wd = rh_q;
              end
              rh_d    = tid_idx;
              stat_we = 1'b1;
              stat_wa = tid_idx;
              stat_wd = ST_READY;
            end
            st_d = S_OUT;
          end
          OP_ADD: begin
            if (!tid_ok || stat_rd != ST_DEAD || tid_idx == idl) begin
              err_d = 1'b1;
            end else begin
              if (re_q) begin
                rh_d = tid_idx;
                re_d = 1'b0;
              end else begin
                rl_we = 1'b1;
                rl_wa = rt_q;
                rl_wd = tid_idx;
              end
              rt_d    = tid_idx;
              stat_we = 1'b1;
              stat_wa = tid_idx;
              stat_wd = ST_READY;
            end
            st_d = S_OUT;
          end
          OP_SLEEP: begin
            if (cur_q == idl || slp_rd) begin
              err_d = 1'b1;
              st_d  = S_OUT;
            end else begin
              wv_d    = wake_new;
              wk_we   = 1'b1;
              wk_wa   = cur_q;
              wk_wd   = wake_new;
              stat_we = 1'b1;
              stat_wa = cur_q;
              stat_wd = ST_BLOCKED;
              slp_we  = 1'b1;
              slp_wa  = cur_q;
              slp_wd  = 1'b1;
              st_d    = S_SI0;
            end
          end
          OP_TICK: begin
            tick_d = tick_q + TickW'(1);
            st_d   = S_TK0;
          end
          default: begin
            err_d = 1'b1;
            st_d  = S_OUT;
          end
        endcase
      end
      S_PUSH: begin
        // Requeue the preempted task at the tail.
        if (push_q) begin
          if (re_q) begin
            rh_d = cur_q;
            re_d = 1'b0;
          end else begin
            rl_we = 1'b1;
            rl_wa = rt_q;
            rl_wd = cur_q;
          end
          rt_d    = cur_q;
          stat_we = 1'b1;
          stat_wa = cur_q;
          stat_wd = ST_READY;
        end
        st_d = S_POP;
      end
      S_POP: begin
        stat_we = 1'b1;
        stat_wd = ST_RUNNING;
        if (re_q) begin
          cur_d   = idl;
          stat_wa = idl;
          st_d    = S_OUT;
        end else begin
          cur_d   = rh_q;
          stat_wa = rh_q;
          rl_ra   = rh_q;
          if (rh_q == rt_q) begin
            re_d = 1'b1;
            st_d = S_OUT;
          end else begin
            st_d = S_POP2;
          end
        end
      end
      S_POP2: begin
        rh_d = rl_rd;
        st_d = S_OUT;
      end
      S_SI0: begin
        if (cnt_q == '0) begin
          sh_d  = cur_q;
          cnt_d = cnt_q + CW'(1);
          st_d  = S_PUSH;
        end else begin
          wk_ra = sh_q;
          p_d   = sh_q;
          i_d   = CW'(1);
          st_d  = S_SI1;
        end
      end
      S_SI1: begin
        // New sleeper wakes before the head: it becomes the head.
        if (cmp_gt) begin
          sl_we = 1'b1;
          sl_wa = cur_q;
          sl_wd = sh_q;
          sh_d  = cur_q;
          cnt_d = cnt_q + CW'(1);
          st_d  = S_PUSH;
        end else begin
          st_d = S_SL_A;
        end
      end
      S_SL_A: begin
        sl_ra = p_q;
        st_d  = (i_q >= cnt_q) ? S_SL_FIN : S_SL_B;
      end
      S_SL_B: begin
        nx_d  = sl_rd;
        wk_ra = sl_rd;
        st_d  = S_SL_C;
      end
      S_SL_C: begin
        // Equal wake times do not stop the walk, so ties keep arrival order.
        if (cmp_gt) begin
          st_d = S_SL_FIN;
        end else begin
          p_d  = nx_q;
          i_d  = i_q + CW'(1);
          st_d = S_SL_A;
        end
      end
      S_SL_FIN: begin
        sl_ra = p_q;
        st_d  = S_SL_F2;
      end
      S_SL_F2: begin
        sl_we = 1'b1;
        sl_wa = cur_q;
        sl_wd = sl_rd;
        st_d  = S_SL_F3;
      end
      S_SL_F3: begin
        sl_we = 1'b1;
        sl_wa = p_q;
        sl_wd = cur_q;
        cnt_d = cnt_q + CW'(1);
        st_d  = S_PUSH;
      end
      S_TK0: begin
        stat_ra = sh_q;
        wk_ra   = sh_q;
        st_d    = (cnt_q == '0) ? S_OUT : S_TK1;
      end
      S_TK1: begin
        // Head has expired when its wake time is not past the counter.
        if (cmp_gt) begin
          st_d = S_OUT;
        end else begin
          t_d   = sh_q;
          blk_d = (stat_rd == ST_BLOCKED);
          sl_ra = sh_q;
          st_d  = S_TK2;
        end
      end
      S_TK2: begin
        cnt_d  = cnt_q - CW'(1);
        sh_d   = (cnt_q == CW'(1)) ? '0 : sl_rd;
        slp_we = 1'b1;
        slp_wa = t_q;
        slp_wd = 1'b0;
        if (blk_q) begin
          if (re_q) begin
            rt_d = t_q;
            re_d = 1'b0;
          end else begin
            rl_we = 1'b1;
            rl_wa = t_q;
            rl_wd = rh_q;
          end
          rh_d    = t_q;
          stat_we = 1'b1;
          stat_wa = t_q;
          stat_wd = ST_READY;
          woken_d = (woken_q == '1) ? woken_q : woken_q + WokW'(1);
        end
        st_d = S_TK0;
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d     = 1'b1;
          o_task_d = IdW'(cur_q);
          o_sw_d   = (cur_q != prev_q);
          o_wk_d   = woken_q;
          o_err_d  = err_q;
          st_d     = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cur_q  <= '0;
      rh_q   <= '0;
      rt_q   <= '0;
      re_q   <= 1'b1;
      sh_q   <= '0;
      cnt_q  <= '0;
      tick_q <= '0;
      idle_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      cur_q  <= cur_d;
      rh_q   <= rh_d;
      rt_q   <= rt_d;
      re_q   <= re_d;
      sh_q   <= sh_d;
      cnt_q  <= cnt_d;
      tick_q <= tick_d;
      ov_q   <= ov_d;
      if (cfg_we_i) begin
        idle_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    tid_q    <= tid_d;
    dur_q    <= dur_d;
    prev_q   <= prev_d;
    err_q    <= err_d;
    woken_q  <= woken_d;
    push_q   <= push_d;
    wv_q     <= wv_d;
    p_q      <= p_d;
    nx_q     <= nx_d;
    i_q      <= i_d;
    t_q      <= t_d;
    blk_q    <= blk_d;
    o_task_q <= o_task_d;
    o_sw_q   <= o_sw_d;
    o_wk_q   <= o_wk_d;
    o_err_q  <= o_err_d;
  end

  assign in_stall_o     = (st_q != S_IDLE);
  assign out_valid_o    = ov_q;
  assign running_task_o = o_task_q;
  assign switched_o     = o_sw_q;
  assign woken_count_o  = o_wk_q;
  assign error_o        = o_err_q;

endmodule

`default_nettype wire

>>> sim/tb_round_robin_task_scheduler_core.sv
// Self-checking testbench for round_robin_task_scheduler_core.
// Depends on rrts_pkg and the scheduler RTL. An internal scheduler model predicts each
// result, and the test runs several phases of idle-task setting and handshake pressure.
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler_core;
  import rrts_pkg::*;

  localparam int          NumTasks   = 16;
  localparam logic [2:0]  OP_ILLEGAL = 3'd7;
  localparam int          CycleLimit = 900000;
  localparam int          DrainWait  = 40;

  // One result beat as seen on the output port.
  typedef struct packed {
    logic [IdW-1:0]  running;
    logic            switched;
    logic [WokW-1:0] woken;
    logic            error;
  } sched_result_t;

  // A model of the scheduler state. It is updated for each accepted input beat and
  // keeps the expected results in arrival order.
  class sched_scoreboard;
    logic [1:0]       status [NumTasks];
    logic [IdW-1:0]   rlink [NumTasks];
    logic [IdW-1:0]   rhead, rtail;
    bit               rempty;
    logic [IdW-1:0]   slink [NumTasks];
    logic [IdW-1:0]   shead;
    int               scount;
    logic [TickW-1:0] wake [NumTasks];
    logic [IdW-1:0]   cur;
    logic [TickW-1:0] now;
    logic [IdW-1:0]   idle;
    sched_result_t    pending [$];
    int               mismatches;

    function new();
      for (int i = 0; i < NumTasks; i++) begin
        status[i] = ST_DEAD;
        rlink[i]  = '0;
        slink[i]  = '0;
        wake[i]   = '0;
      end
      rhead = '0; rtail = '0; rempty = 1'b1;
      shead = '0; scount = 0;
      now = '0; idle = '0; cur = '0;
      status[0] = ST_RUNNING;
      mismatches = 0;
    endfunction

    function void set_idle(logic [IdW-1:0] id);
      idle = id;
    endfunction

    function void push_tail(logic [IdW-1:0] t);
      if (rempty) begin
        rhead = t;
        rempty = 1'b0;
      end else begin
        rlink[rtail] = t;
      end
      rtail = t;
      status[t] = ST_READY;
    endfunction

    function void push_front(logic [IdW-1:0] t);
      if (rempty) begin
        rtail = t;
        rempty = 1'b0;
      end else begin
        rlink[t] = rhead;
      end
      rhead = t;
      status[t] = ST_READY;
    endfunction

    function bit is_sleeping(logic [IdW-1:0] t);
      logic [IdW-1:0] p;
      p = shead;
      for (int i = 0; i < scount; i++) begin
        if (p == t) return 1'b1;
        p = slink[p];
      end
      return 1'b0;
    endfunction

    // Requeue the running task unless it is the idle one, then take the head, or the idle task if the queue is empty.
    function bit switch_task();
      logic [IdW-1:0] prev;
      prev = cur;
      if (status[prev] == ST_RUNNING && prev != idle) push_tail(prev);
      if (rempty) begin
        cur = idle;
      end else begin
        cur = rhead;
        if (rhead == rtail) rempty = 1'b1;
        else rhead = rlink[rhead];
      end
      status[cur] = ST_RUNNING;
      return cur != prev;
    endfunction

    // Sorted insert; a new sleeper goes after those with an equal wake time.
    function void insert_sleeper(logic [IdW-1:0] t, logic [TickW-1:0] w);
      logic [IdW-1:0] p, nx;
      wake[t] = w;
      if (scount == 0) begin
        shead = t;
      end else if (wake[shead] > w) begin
        slink[t] = shead;
        shead = t;
      end else begin
        p = shead;
        for (int i = 1; i < scount; i++) begin
          nx = slink[p];
          if (wake[nx] > w) break;
          p = nx;
        end
        slink[t] = slink[p];
        slink[p] = t;
      end
      scount++;
    endfunction

    // Random task with the given status (a blocked one only if not sleeping), or any task if there is none.
    function logic [IdW-1:0] pick(logic [1:0] st);
      logic [IdW-1:0] c [$];
      for (int i = 0; i < NumTasks; i++)
        if (status[i] == st && !(st == ST_BLOCKED && is_sleeping(IdW'(i))))
          c.push_back(IdW'(i));
      if (c.size() == 0) return IdW'($urandom_range(0, NumTasks - 1));
      return c[$urandom_range(0, c.size() - 1)];
    endfunction

    function void note_input(logic [2:0] op, logic [IdW-1:0] tid, logic [DurW-1:0] dur);
      sched_result_t  r;
      logic [IdW-1:0] t;
      int             woken;
      r = '0;
      woken = 0;
      case (op)
        OP_YIELD: r.switched = switch_task();
        OP_BLOCK: begin
          if (cur == idle) r.error = 1'b1;
          else begin
            status[cur] = ST_BLOCKED;
            r.switched = switch_task();
          end
        end
        OP_UNBLOCK: begin
          if (status[tid] != ST_BLOCKED || is_sleeping(tid)) r.error = 1'b1;
          else push_front(tid);
        end
        OP_ADD: begin
          if (status[tid] != ST_DEAD || tid == idle) r.error = 1'b1;
          else push_tail(tid);
        end
        OP_TERMINATE: begin
          if (cur == idle) r.error = 1'b1;
          else begin
            status[cur] = ST_DEAD;
            r.switched = switch_task();
          end
        end
        OP_SLEEP: begin
          if (cur == idle || is_sleeping(cur)) r.error = 1'b1;
          else begin
            insert_sleeper(cur, now + TickW'(dur));
            status[cur] = ST_BLOCKED;
            r.switched = switch_task();
          end
        end
        OP_TICK: begin
          now++;
          while (scount > 0 && wake[shead] <= now) begin
            t = shead;
            shead = slink[t];
            scount--;
            if (scount == 0) shead = '0;
            // A sleeper that was terminated meanwhile is dropped silently.
            if (status[t] == ST_BLOCKED) begin
              push_front(t);
              woken++;
            end
          end
        end
        default: r.error = 1'b1;
      endcase
      r.woken = (woken > 31) ? 5'd31 : WokW'(woken);
      r.running = cur;
      pending.push_back(r);
    endfunction

    function void check_result(sched_result_t act);
      sched_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", act);
        return;
      end
      exp = pending.pop_front();
      if (act.running !== exp.running || act.switched !== exp.switched ||
          act.woken !== exp.woken || act.error !== exp.error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected run=%0d sw=%0d woken=%0d err=%0d, ",
                   exp.running, exp.switched, exp.woken, exp.error,
                   "got run=%0d sw=%0d woken=%0d err=%0d",
                   act.running, act.switched, act.woken, act.error);
      end
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              cfg_we_i = 0;
  logic [IdW-1:0]    cfg_wdata_i = '0;
  logic              in_valid_i = 0;
  logic              in_stall_o;
  logic [2:0]        op_i = '0;
  logic [IdW-1:0]    task_id_i = '0;
  logic [DurW-1:0]   duration_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 0;
  logic [IdW-1:0]    running_task_o;
  logic              switched_o;
  logic [WokW-1:0]   woken_count_o;
  logic              error_o;

  sched_scoreboard sb = new();
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int cycles = 0;

  round_robin_task_scheduler_core #(.NUM_TASKS(NumTasks)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .op_i, .task_id_i, .duration_i,
    .out_valid_o, .out_stall_i, .running_task_o, .switched_o,
    .woken_count_o, .error_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[round_robin_task_scheduler_core] ERROR");
      $finish;
    end
  end

  // The result side stalls at random while the phase asks for it. Stall changes
  // at the falling edge, and the beat is sampled at the rising edge.
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{running_task_o, switched_o, woken_count_o, error_o});
  end

  // Send one input beat. Valid is left high after the accept, so a following
  // beat can go out back to back. The caller lowers valid at the end.
  task automatic send_beat(logic [2:0] op, logic [IdW-1:0] tid, logic [DurW-1:0] dur);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid_i = 0;
      @(negedge clk_i);
    end
    in_valid_i = 1;
    op_i = op;
    task_id_i = tid;
    duration_i = dur;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_input(op, tid, dur);
  endtask

  // The idle-task register is written only when the block is quiet.
  task automatic write_idle(logic [IdW-1:0] id);
    @(negedge clk_i);
    in_valid_i = 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    cfg_we_i = 1;
    cfg_wdata_i = id;
    sb.set_idle(id);
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  // Mostly well-formed traffic that keeps tasks cycling through every status.
  task automatic random_beats(int count);
    int             sel;
    logic [2:0]     op;
    logic [IdW-1:0] tid;
    logic [DurW-1:0] dur;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      tid = IdW'($urandom_range(0, NumTasks - 1));
      dur = $urandom_range(0, 6);
      if ($urandom_range(0, 19) == 0) dur = $urandom;
      if (sel < 16) begin
        op = OP_ADD;
        if (sel < 12) tid = sb.pick(ST_DEAD);
      end else if (sel < 36) op = OP_YIELD;
      else if (sel < 45) op = OP_BLOCK;
      else if (sel < 56) begin
        op = OP_UNBLOCK;
        if (sel < 53) tid = sb.pick(ST_BLOCKED);
      end else if (sel < 63) op = OP_TERMINATE;
      else if (sel < 77) op = OP_SLEEP;
      else if (sel < 97) op = OP_TICK;
      else op = OP_ILLEGAL;
      send_beat(op, tid, dur);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed beats: error paths, the queue edges, and extreme durations.
    send_beat(OP_ILLEGAL, 4'd0, 32'd0);
    send_beat(OP_BLOCK, 4'd0, 32'd0);
    send_beat(OP_TERMINATE, 4'd0, 32'd0);
    send_beat(OP_SLEEP, 4'd0, 32'd3);
    send_beat(OP_ADD, 4'd0, 32'd0);
    send_beat(OP_YIELD, 4'd0, 32'd0);
    send_beat(OP_ADD, 4'd15, 32'd0);
    send_beat(OP_ADD, 4'd1, 32'd0);
    send_beat(OP_ADD, 4'd15, 32'd0);
    send_beat(OP_UNBLOCK, 4'd1, 32'd0);
    send_beat(OP_YIELD, 4'd0, 32'd0);
    send_beat(OP_BLOCK, 4'd0, 32'd0);
    send_beat(OP_UNBLOCK, 4'd15, 32'd0);
    send_beat(OP_SLEEP, 4'd0, 32'd0);
    send_beat(OP_SLEEP, 4'd0, 32'hFFFF_FFFF);
    send_beat(OP_TICK, 4'd0, 32'd0);
    send_beat(OP_ADD, 4'd7, 32'd0);
    send_beat(OP_YIELD, 4'd0, 32'd0);
    send_beat(OP_SLEEP, 4'd0, 32'd1);
    send_beat(OP_UNBLOCK, 4'd7, 32'd0);
    send_beat(OP_TICK, 4'd0, 32'd0);
    send_beat(OP_TICK, 4'd0, 32'd0);
    send_beat(OP_TERMINATE, 4'd0, 32'd0);
    send_beat(OP_YIELD, 4'd0, 32'd0);

    // Phases of handshake pressure, each with its own idle task.
    write_idle(4'd15);
    random_beats(180);
    in_gap_pct = 67;
    write_idle(4'($urandom_range(1, 14)));
    random_beats(180);
    in_gap_pct = 0;
    out_stall_pct = 67;
    write_idle(4'd0);
    random_beats(180);
    in_gap_pct = 12;
    out_stall_pct = 12;
    write_idle(4'($urandom_range(0, 15)));
    random_beats(180);

    @(negedge clk_i);
    in_valid_i = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("[round_robin_task_scheduler_core] OK");
    end else begin
      $display("[round_robin_task_scheduler_core] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_cmp.sv
hw/rtl/rrts_ram.sv
hw/rtl/rrts_vram.sv
hw/rtl/round_robin_task_scheduler_core.sv
sim/tb_round_robin_task_scheduler_core.sv
